// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the edit distance engine.
// Each macro expects the module to have a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edit distance engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edit distance engine: next-cycle check failed");

`endif

// ----- rtl/core/ed_pkg.sv -----
`default_nettype none

package ed_pkg;

  // Longest word that the cell chain holds.
  localparam int MAX_LEN = 16;

  // Width of a length count and of one row entry (both reach MAX_LEN).
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // Width of the distance field and its largest value.
  localparam int DIST_W   = 5;
  localparam int DIST_MAX = 31;

  // Action codes carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_FIRST  = 2'd0,
    ACT_SECOND = 2'd1,
    ACT_END    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Control state of the top level.
  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Row token handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic [7:0]       ch;
    logic [CNT_W-1:0] val_new;
    logic [CNT_W-1:0] val_old;
  } token_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             clear;
    logic             load;
    logic [CNT_W-1:0] load_index;
  } cell_ctrl_t;

  // Clamp a row entry to the distance field.
  function automatic logic [DIST_W-1:0] clamp_dist(input logic [CNT_W-1:0] v);
    logic [CNT_W:0] wide;
    wide = {1'b0, v};
    if (wide > (CNT_W + 1)'(DIST_MAX)) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(v);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ed_cell.sv -----
`default_nettype none

module ed_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ed_pkg::CNT_W-1:0] cell_index,
  input  ed_pkg::cell_ctrl_t      ctrl,
  input  logic [7:0]              load_byte,
  input  ed_pkg::token_t          tok_in,
  output ed_pkg::token_t          tok_out,
  output logic [ed_pkg::CNT_W-1:0] value
);
  import ed_pkg::*;

  logic [7:0]       ch_store;
  logic             cost;
  logic [CNT_W:0]   up_cost;
  logic [CNT_W:0]   left_cost;
  logic [CNT_W:0]   diag_cost;
  logic [CNT_W:0]   best;
  logic [CNT_W-1:0] value_next;

  // One step of the row recurrence for this column.
  always_comb begin
    cost      = (ch_store != tok_in.ch);
    up_cost   = {1'b0, value} + (CNT_W + 1)'(1);
    left_cost = {1'b0, tok_in.val_new} + (CNT_W + 1)'(1);
    diag_cost = {1'b0, tok_in.val_old} + (CNT_W + 1)'(cost);
    best      = up_cost;
    if (left_cost < best) begin
      best = left_cost;
    end
    if (diag_cost < best) begin
      best = diag_cost;
    end
    // A row entry never exceeds MAX_LEN, so the top bit is always clear.
    value_next = best[CNT_W-1:0];
  end

  // Stored byte of the first word for this column.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_store <= '0;
    end else if (ctrl.load && (ctrl.load_index == cell_index)) begin
      ch_store <= load_byte;
    end
  end

  // Row entry and the token passed on to the next cell.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value         <= cell_index;
      tok_out.valid <= 1'b0;
    end else begin
      if (tok_in.valid) begin
        value <= value_next;
      end
      tok_out.valid <= tok_in.valid;
    end
    tok_out.ch      <= tok_in.ch;
    tok_out.val_new <= value_next;
    tok_out.val_old <= value;
  end

`include "assert_macros.svh"

  // A row entry of column j never exceeds MAX_LEN.
  `ED_ASSERT_IMP(a_value_bound, 1'b1, value <= CNT_W'(MAX_LEN))
  // Tokens advance exactly one cell per cycle.
  `ED_ASSERT_NXT(a_token_moves, tok_in.valid && !ctrl.clear, tok_out.valid)
  // The diagonal entry (the old entry of the column to the left) never exceeds this cell's old entry by more than one.
  `ED_ASSERT_IMP(a_left_close, tok_in.valid,
                 ({1'b0, tok_in.val_old} <= {1'b0, value} + (CNT_W + 1)'(1)))

endmodule

`default_nettype wire

// ----- rtl/core/edit_distance_engine_top.sv -----
`default_nettype none

// Levenshtein edit distance between two byte words of up to MAX_LEN bytes each.
// The input tuser carries the action (first-word byte, second-word byte, end of
// pair) and tdata the byte. Byte items are taken one per cycle: first-word bytes
// are written into a chain of MAX_LEN cells, and each second-word byte starts a
// row token that walks down the chain one cell per cycle, so rows overlap as a
// diagonal wavefront. An end item waits until the last token has left the chain
// and until the output register is free, then loads the distance and overflow
// flag into the output register and clears the block for the next pair. Bytes
// beyond MAX_LEN, and first-word bytes after the second word has begun, are
// dropped and flagged. Input is not taken while an end item is pending.
module edit_distance_engine_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_value
  input  logic [1:0] s_tuser,   // [1:0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] distance, [7:5] zero
  output logic       m_tuser    // [0] overflow_flag
);
  import ed_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] first_length;
  logic [CNT_W-1:0] second_length;
  logic             second_started;
  logic             overflow_seen;
  token_t           feed_tok;
  logic [DIST_W-1:0] distance;
  logic             overflow_flag;

  logic             take;
  logic             busy;
  logic             finish;
  logic             first_ok;
  logic             second_ok;
  action_t          action;
  cell_ctrl_t       ctrl;

  token_t           tok      [MAX_LEN+1];
  logic [CNT_W-1:0] row_val  [MAX_LEN+1];
  logic [MAX_LEN:0] tok_valid;

  assign action = action_t'(s_tuser);
  assign take   = s_tvalid && s_tready;

  // Column zero of the row is the count of second-word bytes.
  assign tok[0]     = feed_tok;
  assign row_val[0] = second_length;

  // Chain of cells, column j holding byte j-1 of the first word.
  genvar j;
  generate
    for (j = 1; j <= MAX_LEN; j++) begin : g_cell
      ed_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cell_index (CNT_W'(j)),
        .ctrl       (ctrl),
        .load_byte  (s_tdata),
        .tok_in     (tok[j-1]),
        .tok_out    (tok[j]),
        .value      (row_val[j])
      );
    end
    for (j = 0; j <= MAX_LEN; j++) begin : g_valid
      assign tok_valid[j] = tok[j].valid;
    end
  endgenerate

  assign busy = |tok_valid;

  // Which byte items are kept.
  always_comb begin
    first_ok  = !second_started && (first_length < CNT_W'(MAX_LEN));
    second_ok = second_length < CNT_W'(MAX_LEN);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (take && action == ACT_END) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready = 1'b0;
    finish   = 1'b0;
    unique case (state)
      ST_RUN:   s_tready = 1'b1;
      ST_DRAIN: finish   = !busy && (!m_tvalid || m_tready);
      default: begin
        s_tready = 1'b0;
        finish   = 1'b0;
      end
    endcase
  end

  // Broadcast control to the cells.
  always_comb begin
    ctrl.clear      = finish;
    ctrl.load       = take && (action == ACT_FIRST) && first_ok;
    ctrl.load_index = first_length + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Word lengths, order and overflow tracking.
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      first_length   <= '0;
      second_length  <= '0;
      second_started <= 1'b0;
      overflow_seen  <= 1'b0;
    end else if (take) begin
      case (action)
        ACT_FIRST: begin
          if (first_ok) begin
            first_length <= first_length + CNT_W'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        ACT_SECOND: begin
          if (second_ok) begin
            second_length  <= second_length + CNT_W'(1);
            second_started <= 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Row token for a kept second-word byte enters the chain.
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      feed_tok.valid <= 1'b0;
    end else begin
      feed_tok.valid <= take && (action == ACT_SECOND) && second_ok;
    end
    feed_tok.ch      <= s_tdata;
    feed_tok.val_new <= second_length + CNT_W'(1);
    feed_tok.val_old <= second_length;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      distance      <= clamp_dist(row_val[first_length]);
      overflow_flag <= overflow_seen;
    end
  end

  assign m_tdata = {{(8 - DIST_W){1'b0}}, distance};
  assign m_tuser = overflow_flag;

`include "assert_macros.svh"

  // Clearing a pair leaves every count at zero.
  `ED_ASSERT_NXT(a_clear_counts, finish,
                 first_length == '0 && second_length == '0 && !overflow_seen)
  // A row token only exists once the second word has begun.
  `ED_ASSERT_IMP(a_feed_started, feed_tok.valid, second_started)
  // Once a result is produced, the output is valid and no row token is being fed.
  `ED_ASSERT_NXT(a_result_loaded, finish, m_tvalid && !feed_tok.valid)

endmodule

`default_nettype wire

// ----- dv/edit_distance_engine_top_tb.sv -----
`default_nettype none

module edit_distance_engine_top_tb;
  import ed_pkg::*;

  // One distance result as the block should report it.
  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } distance_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;     // [7:0] char_value
  logic [1:0] s_tuser = ACT_NONE;  // [1:0] action
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;             // [4:0] distance, [7:5] zero
  logic       m_tuser;             // [0] overflow_flag

  // Shadow copy of the word store and the current distance row.
  logic [7:0] word_bytes [MAX_LEN];
  int         edit_row [MAX_LEN + 1];
  int         word_len;
  int         other_len;
  bit         other_started;
  bit         dropped_seen;

  distance_result_t pending_distances [$];

  int error_count = 0;
  int bytes_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_off_left = 0;

  edit_distance_engine_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Clears the shadow state, as after reset or an end item.
  function automatic void clear_words();
    for (int j = 0; j < MAX_LEN; j++) word_bytes[j] = 8'h00;
    for (int j = 0; j <= MAX_LEN; j++) edit_row[j] = 0;
    word_len = 0;
    other_len = 0;
    other_started = 1'b0;
    dropped_seen = 1'b0;
  endfunction

  // Applies one accepted item to the shadow state and queues any distance it yields.
  function automatic void update_edit_rows(action_t act, logic [7:0] ch);
    int diag;
    int nxt;
    int cost;
    int dist_val;
    distance_result_t res;
    case (act)
      ACT_FIRST: begin
        if (other_started || word_len >= MAX_LEN) begin
          dropped_seen = 1'b1;
        end else begin
          word_bytes[word_len] = ch;
          word_len++;
        end
      end
      ACT_SECOND: begin
        if (other_len >= MAX_LEN) begin
          dropped_seen = 1'b1;
        end else begin
          // The first byte of the second word starts from the identity row.
          if (!other_started) begin
            for (int j = 0; j <= MAX_LEN; j++) edit_row[j] = j;
            other_started = 1'b1;
          end
          other_len++;
          diag = edit_row[0];
          edit_row[0] = other_len;
          for (int j = 1; j <= word_len; j++) begin
            cost = (word_bytes[j - 1] != ch) ? 1 : 0;
            nxt = diag + cost;
            if (edit_row[j] + 1 < nxt) nxt = edit_row[j] + 1;
            if (edit_row[j - 1] + 1 < nxt) nxt = edit_row[j - 1] + 1;
            diag = edit_row[j];
            edit_row[j] = nxt;
          end
        end
      end
      ACT_END: begin
        dist_val = other_started ? edit_row[word_len] : word_len;
        if (dist_val > DIST_MAX) dist_val = DIST_MAX;
        res.distance = DIST_W'(dist_val);
        res.overflow = dropped_seen;
        pending_distances.push_back(res);
        clear_words();
      end
      default: ;
    endcase
  endfunction

  // Offers one item, with random idle cycles ahead of it, until it is accepted.
  task automatic send_item(action_t act, logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    update_edit_rows(act, ch);
    if (act != ACT_NONE) bytes_sent++;
  endtask

  // Stops offering items and waits until every queued distance has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    // An end item may still be waiting on the row wavefront.
    repeat (2 * MAX_LEN + 8) @(posedge clk);
  endtask

  // Picks a byte either from the whole range or from a tiny alphabet.
  function automatic logic [7:0] pick_char(int alpha, logic [7:0] base);
    if (alpha == 0) return 8'($urandom_range(0, 255));
    return base + 8'($urandom_range(0, alpha));
  endfunction

  // Word lengths: mostly short, sometimes empty, full or beyond capacity.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return MAX_LEN + $urandom_range(1, 3);
    if (r == 1) return MAX_LEN;
    if (r == 2) return 0;
    return $urandom_range(1, 8);
  endfunction

  // Sends a whole pair of words and its end item, with an optional late first-word byte and optional noise.
  task automatic send_pair(int len1, int len2, int alpha, bit late_byte, bit noise);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len1; i++) begin
      send_item(ACT_FIRST, pick_char(alpha, base));
      if (noise && $urandom_range(0, 3) == 0) send_item(ACT_NONE, 8'($urandom));
    end
    for (int i = 0; i < len2; i++) begin
      send_item(ACT_SECOND, pick_char(alpha, base));
      if (late_byte && i == len2 / 2) send_item(ACT_FIRST, pick_char(alpha, base));
      if (noise && $urandom_range(0, 3) == 0) send_item(ACT_NONE, 8'($urandom));
    end
    send_item(ACT_END, 8'($urandom));
  endtask

  // Empty words, single and matching bytes, an ignored action and a late byte.
  task automatic test_directed_cases();
    send_item(ACT_END, 8'h00);
    send_item(ACT_FIRST, 8'h00);
    send_item(ACT_FIRST, 8'hFF);
    send_item(ACT_END, 8'h00);
    send_item(ACT_SECOND, 8'h00);
    send_item(ACT_SECOND, 8'hFF);
    send_item(ACT_NONE, 8'hA5);
    send_item(ACT_END, 8'h00);
    send_item(ACT_FIRST, 8'h5A);
    send_item(ACT_FIRST, 8'h3C);
    send_item(ACT_SECOND, 8'h5A);
    send_item(ACT_SECOND, 8'h3C);
    send_item(ACT_END, 8'h00);
    send_item(ACT_FIRST, 8'h01);
    send_item(ACT_SECOND, 8'h02);
    send_item(ACT_FIRST, 8'h80);
    send_item(ACT_END, 8'hFF);
    wait_results_drained();
  endtask

  // Words at and beyond capacity, including the largest distance.
  task automatic test_capacity_limits();
    send_pair(MAX_LEN + 2, 0, 0, 1'b0, 1'b0);
    send_pair(MAX_LEN, MAX_LEN + 2, 0, 1'b0, 1'b0);
    send_pair(MAX_LEN, MAX_LEN, 1, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Random pairs under one idling setting; most are well formed.
  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_bytes);
    int target;
    int kind;
    target = bytes_sent + n_bytes;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (bytes_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_pair(pick_len(), pick_len(), $urandom_range(0, 2), 1'b0, 1'b0);
      end else if (kind < 9) begin
        send_pair(pick_len(), pick_len(), $urandom_range(0, 2), 1'b1, 1'b1);
      end else begin
        // Loose items in any order, closed by an end item.
        repeat ($urandom_range(1, 6)) begin
          send_item(action_t'($urandom_range(0, 3)), 8'($urandom));
        end
        send_item(ACT_END, 8'($urandom));
      end
    end
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while short pairs keep coming.
  task automatic test_output_hold_off();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 300;
    repeat (12) send_pair($urandom_range(0, 2), $urandom_range(0, 2), 1, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Compares each accepted result with the oldest queued distance.
  always @(posedge clk) begin : result_check
    distance_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_distances.size() == 0) begin
        $error("unexpected result: distance %0d, overflow_flag %0d", m_tdata[4:0], m_tuser);
        error_count++;
      end else begin
        want = pending_distances.pop_front();
        if (m_tdata[4:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[4:0]);
          error_count++;
        end
        if (m_tuser !== want.overflow) begin
          $error("overflow_flag: expected %0d, got %0d", want.overflow, m_tuser);
          error_count++;
        end
        if (m_tdata[7:5] !== 3'b000) begin
          $error("tdata padding: expected 0, got %0d", m_tdata[7:5]);
          error_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    clear_words();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_capacity_limits();
    test_random_traffic(0, 0, 175);
    test_random_traffic(61, 0, 175);
    test_random_traffic(0, 61, 175);
    test_random_traffic(11, 11, 175);
    test_output_hold_off();
    if (pending_distances.size() != 0) begin
      $error("%0d expected results never arrived", pending_distances.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("edit_distance_engine_top test passed");
    end else begin
      $display("edit_distance_engine_top test failed");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #5000000;
    $display("edit_distance_engine_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
